[sv/rwmf_pkg.sv]
package rwmf_pkg;

    localparam int RADIUS    = 1;
    localparam int MAX_WIDTH = 1024;
    localparam int WIN       = 2 * RADIUS + 1;
    localparam int AREA      = WIN * WIN;
    localparam int LINES     = 2 * RADIUS;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] med_red;
        logic [7:0] med_green;
        logic [7:0] med_blue;
        logic       frame_done;
    } pixel_out_t;

    // item handed from front to back
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             emit;
        logic             last;
        logic [23:0]      px;
    } job_t;

    typedef logic [7:0] sample_t;
    typedef sample_t [AREA-1:0] chan_win_t;

endpackage

[sv/rgb_window_median_filter_core.sv]
// RGB 3x3 median filter for a pre-padded raster frame, one pixel per clock
// sustained while out_ready stays high. Each accepted pixel produces one
// result once row and column are both at least 2; frame_done marks the last
// result of the frame. The pipe runs through the line store read, the window
// shift and a four-stage sorting network; out_ready low with a result held
// stalls the back pipe and a two-entry queue absorbs the front. Config writes restart the frame.
module rgb_window_median_filter_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rwmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rwmf_pkg::pixel_in_t            in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output rwmf_pkg::pixel_out_t           out_data
);

    logic           f_valid, f_ready, q_valid, q_ready;
    rwmf_pkg::job_t f_job, q_job;

    rwmf_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    rwmf_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    rwmf_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !f_ready |-> !in_ready)
        else $error("input taken while queue full");

endmodule

[sv/rwmf_front.sv]
module rwmf_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rwmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rwmf_pkg::pixel_in_t           in_data,
    output logic                          job_valid,
    input  logic                          job_ready,
    output rwmf_pkg::job_t                job
);

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [rwmf_pkg::COL_W-1:0] col_reg, col_next;
    logic [rwmf_pkg::ROW_W-1:0] row_reg, row_next;
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [rwmf_pkg::COL_W-1:0] c_use;
    logic [rwmf_pkg::ROW_W-1:0] r_use;
    logic col_end, row_end, xfer;

    assign cfg_ready = 1'b1;
    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign xfer      = in_valid && job_ready;

    always_comb
    begin
        if (width_reg < 11'(rwmf_pkg::WIN))
            w_eff = 11'(rwmf_pkg::WIN);
        else if (width_reg > 11'(rwmf_pkg::MAX_WIDTH))
            w_eff = 11'(rwmf_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg < 13'(rwmf_pkg::WIN))
            h_eff = 13'(rwmf_pkg::WIN);
        else if (height_reg > 13'(rwmf_pkg::MAX_HEIGHT))
            h_eff = 13'(rwmf_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
        c_use   = ({1'b0, col_reg} >= w_eff) ? rwmf_pkg::COL_W'(w_eff - 11'd1) : col_reg;
        r_use   = ({1'b0, row_reg} >= h_eff) ? rwmf_pkg::ROW_W'(h_eff - 13'd1) : row_reg;
        col_end = ({1'b0, c_use} + 11'd1) >= w_eff;
        row_end = ({1'b0, r_use} + 13'd1) >= h_eff;
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : r_use + 1'b1;
        end
        else
        begin
            col_next = c_use + 1'b1;
            row_next = r_use;
        end
        job.col  = c_use;
        job.emit = (r_use >= rwmf_pkg::ROW_W'(rwmf_pkg::LINES))
                && (c_use >= rwmf_pkg::COL_W'(rwmf_pkg::LINES));
        job.last = col_end && row_end;
        // red in the low byte, blue in the high byte
        job.px   = {in_data.in_blue, in_data.in_green, in_data.in_red};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd768;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rwmf_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data[10:0];
                rwmf_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data[12:0];
                default: ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (xfer)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[sv/rwmf_fifo.sv]
module rwmf_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rwmf_pkg::job_t  wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rwmf_pkg::job_t  rd_data
);

    rwmf_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

endmodule

[sv/rwmf_back.sv]
module rwmf_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  rwmf_pkg::job_t       job,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rwmf_pkg::pixel_out_t out_data
);

    localparam int LW = 24 * rwmf_pkg::LINES;
    localparam int SCNT = 4;

    // stage A: line store read
    logic [LW-1:0] line_mem [rwmf_pkg::MAX_WIDTH];
    logic [LW-1:0] rd_reg;
    logic          a_vld_reg;
    rwmf_pkg::job_t a_job_reg;
    // stage B: window
    logic [23:0]   win_reg [rwmf_pkg::WIN][rwmf_pkg::WIN];
    logic          b_vld_reg, b_emit_reg, b_last_reg;
    // sort pipeline
    rwmf_pkg::chan_win_t s_reg [SCNT+1][3];
    logic          s_vld_reg [SCNT+1];
    logic          s_last_reg [SCNT+1];
    rwmf_pkg::pixel_out_t o_reg;
    logic          o_vld_reg;
    logic          adv;
    logic [23:0]   col_w [rwmf_pkg::WIN];
    rwmf_pkg::chan_win_t s_nx [SCNT][3];

    // whole pipe advances together; output register is the only stall point
    assign adv       = !o_vld_reg || out_ready;
    assign job_ready = adv;
    assign out_valid = o_vld_reg;
    assign out_data  = o_reg;

    always_ff @(posedge clk)
    begin
        if (adv && job_valid)
        begin
            rd_reg    <= line_mem[job.col];
            a_job_reg <= job;
        end
        if (adv && a_vld_reg)
            line_mem[a_job_reg.col] <= {a_job_reg.px, rd_reg[LW-1:24]};
    end

    always_comb
    begin
        for (int k = 0; k < rwmf_pkg::LINES; k++)
            col_w[k] = rd_reg[24*k +: 24];
        col_w[rwmf_pkg::LINES] = a_job_reg.px;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            b_emit_reg <= 1'b0;
            b_last_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
            for (int i = 0; i <= SCNT; i++)
            begin
                s_vld_reg[i]  <= 1'b0;
                s_last_reg[i] <= 1'b0;
            end
            for (int r = 0; r < rwmf_pkg::WIN; r++)
                for (int c = 0; c < rwmf_pkg::WIN; c++)
                    win_reg[r][c] <= '0;
        end
        else if (adv)
        begin
            a_vld_reg <= job_valid;
            b_vld_reg <= a_vld_reg;
            if (a_vld_reg)
            begin
                b_emit_reg <= a_job_reg.emit;
                b_last_reg <= a_job_reg.last;
                for (int r = 0; r < rwmf_pkg::WIN; r++)
                begin
                    for (int c = 0; c < rwmf_pkg::WIN - 1; c++)
                        win_reg[r][c] <= win_reg[r][c+1];
                    win_reg[r][rwmf_pkg::WIN-1] <= col_w[r];
                end
            end
            s_vld_reg[0]  <= b_vld_reg && b_emit_reg;
            s_last_reg[0] <= b_last_reg;
            for (int i = 1; i <= SCNT; i++)
            begin
                s_vld_reg[i]  <= s_vld_reg[i-1];
                s_last_reg[i] <= s_last_reg[i-1];
            end
            o_vld_reg <= s_vld_reg[SCNT];
        end
        else if (out_ready)
            o_vld_reg <= 1'b0;
    end

    // odd-even transposition sort, ceil(AREA/SCNT) passes in each of SCNT stages
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int st = 0; st < SCNT; st++)
            begin
                s_nx[st][ch] = s_reg[st][ch];
                for (int p = 0; p < (rwmf_pkg::AREA + SCNT - 1) / SCNT; p++)
                    for (int j = (st * ((rwmf_pkg::AREA + SCNT - 1) / SCNT) + p) % 2;
                         j + 1 < rwmf_pkg::AREA; j += 2)
                        if (s_nx[st][ch][j] > s_nx[st][ch][j+1])
                            s_nx[st][ch][j +: 2] = {s_nx[st][ch][j], s_nx[st][ch][j+1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < rwmf_pkg::WIN; r++)
                for (int c = 0; c < rwmf_pkg::WIN; c++)
                    for (int ch = 0; ch < 3; ch++)
                        s_reg[0][ch][r*rwmf_pkg::WIN+c] <= win_reg[r][c][8*ch +: 8];
            for (int st = 0; st < SCNT; st++)
                for (int ch = 0; ch < 3; ch++)
                    s_reg[st+1][ch] <= s_nx[st][ch];
            o_reg.med_red    <= s_reg[SCNT][0][rwmf_pkg::AREA/2];
            o_reg.med_green  <= s_reg[SCNT][1][rwmf_pkg::AREA/2];
            o_reg.med_blue   <= s_reg[SCNT][2][rwmf_pkg::AREA/2];
            o_reg.frame_done <= s_last_reg[SCNT];
        end
    end

endmodule

[verif/rgb_window_median_filter_core_tb.sv]
module rgb_window_median_filter_core_tb;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [rwmf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0]                    cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    rwmf_pkg::pixel_in_t            in_data;
    logic                           out_valid;
    logic                           out_ready;
    rwmf_pkg::pixel_out_t           out_data;

    int error_count = 0;
    int idle_cycles = 0;
    int pixels_sent = 0;
    int medians_seen = 0;
    int frames_seen = 0;
    bit out_stall_en = 1'b1;

    rgb_window_median_filter_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    class median_scoreboard;
        logic [23:0]  rows [rwmf_pkg::LINES][rwmf_pkg::MAX_WIDTH];
        logic [23:0]  win [rwmf_pkg::WIN][rwmf_pkg::WIN];
        int unsigned  col_cnt;
        int unsigned  row_cnt;
        int unsigned  width_reg;
        int unsigned  height_reg;
        rwmf_pkg::pixel_out_t pending_medians [$];

        function new();
            foreach (rows[i, j]) rows[i][j] = '0;
            foreach (win[i, j]) win[i][j] = '0;
            col_cnt = 0;
            row_cnt = 0;
            width_reg = 1024;
            height_reg = 768;
        endfunction

        function void write_reg(logic [rwmf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx == rwmf_pkg::REG_FRAME_WIDTH)
                width_reg = val[10:0];
            else
                height_reg = val[12:0];
            col_cnt = 0;
            row_cnt = 0;
        endfunction

        function logic [7:0] window_median(int sh);
            logic [7:0] v [rwmf_pkg::AREA];
            logic [7:0] t;
            int n;
            n = 0;
            foreach (win[i, j]) v[n++] = win[i][j][sh +: 8];
            for (int i = 0; i < rwmf_pkg::AREA; i++)
                for (int j = 0; j < rwmf_pkg::AREA - 1 - i; j++)
                    if (v[j] > v[j + 1])
                    begin
                        t = v[j];
                        v[j] = v[j + 1];
                        v[j + 1] = t;
                    end
            return v[rwmf_pkg::AREA / 2];
        endfunction

        function void note_pixel(rwmf_pkg::pixel_in_t p);
            int unsigned w, h, c, r;
            logic [23:0] px;
            logic [23:0] column [rwmf_pkg::WIN];
            rwmf_pkg::pixel_out_t e;
            w = width_reg < rwmf_pkg::WIN ? rwmf_pkg::WIN :
                (width_reg > rwmf_pkg::MAX_WIDTH ? rwmf_pkg::MAX_WIDTH : width_reg);
            h = height_reg < rwmf_pkg::WIN ? rwmf_pkg::WIN :
                (height_reg > rwmf_pkg::MAX_HEIGHT ? rwmf_pkg::MAX_HEIGHT : height_reg);
            c = col_cnt >= w ? w - 1 : col_cnt;
            r = row_cnt >= h ? h - 1 : row_cnt;
            px = {p.in_blue, p.in_green, p.in_red};
            for (int k = 0; k < rwmf_pkg::LINES; k++) column[k] = rows[k][c];
            column[rwmf_pkg::LINES] = px;
            for (int k = 0; k < rwmf_pkg::LINES; k++) rows[k][c] = column[k + 1];
            for (int i = 0; i < rwmf_pkg::WIN; i++)
            begin
                for (int j = 0; j < rwmf_pkg::WIN - 1; j++) win[i][j] = win[i][j + 1];
                win[i][rwmf_pkg::WIN - 1] = column[i];
            end
            if (r >= rwmf_pkg::LINES && c >= rwmf_pkg::LINES)
            begin
                e.med_red = window_median(0);
                e.med_green = window_median(8);
                e.med_blue = window_median(16);
                e.frame_done = (r == h - 1) && (c == w - 1);
                pending_medians = {pending_medians, e};
            end
            if (c + 1 >= w)
            begin
                col_cnt = 0;
                row_cnt = (r + 1 >= h) ? 0 : r + 1;
            end
            else
            begin
                col_cnt = c + 1;
                row_cnt = r;
            end
        endfunction

        task check_median(rwmf_pkg::pixel_out_t got);
            rwmf_pkg::pixel_out_t e;
            if (pending_medians.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            e = pending_medians.pop_front();
            if (got.med_red !== e.med_red)
                report_mismatch($sformatf("red %0d exp %0d", got.med_red, e.med_red));
            if (got.med_green !== e.med_green)
                report_mismatch($sformatf("green %0d exp %0d", got.med_green, e.med_green));
            if (got.med_blue !== e.med_blue)
                report_mismatch($sformatf("blue %0d exp %0d", got.med_blue, e.med_blue));
            if (got.frame_done !== e.frame_done)
                report_mismatch($sformatf("frame_done %0b exp %0b", got.frame_done,
                    e.frame_done));
        endtask
    endclass

    median_scoreboard median_sb;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && out_ready)
            begin
                median_sb.check_median(out_data);
                medians_seen++;
                if (out_data.frame_done) frames_seen++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            g = out_stall_en ? pick_gap() : 0;
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [rwmf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        median_sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(rwmf_pkg::pixel_in_t p, bit with_gap);
        int g;
        g = with_gap ? pick_gap() : 0;
        if (g > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= p;
        do @(posedge clk); while (!in_ready);
        median_sb.note_pixel(p);
        pixels_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (median_sb.pending_medians.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic rwmf_pkg::pixel_in_t rand_pixel(int mode);
        rwmf_pkg::pixel_in_t p;
        case (mode)
            0: p = '0;
            1: p = '1;
            default: p = rwmf_pkg::pixel_in_t'($urandom);
        endcase
        return p;
    endfunction

    task automatic send_frame(int w, int h, bit with_gap);
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < w * h; i++)
            send_pixel(rand_pixel(mode < 1 ? $urandom_range(0, 1) : 2), with_gap);
        drop_valid();
    endtask

    initial
    begin
        int w, h, n;
        median_sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: minimum frame with extreme samples, then out-of-range and maximum sizes
        write_reg(rwmf_pkg::REG_FRAME_WIDTH, 16'd3);
        write_reg(rwmf_pkg::REG_FRAME_HEIGHT, 16'd3);
        for (int i = 0; i < 9; i++)
            send_pixel(rand_pixel(i % 2), 1'b0);
        for (int i = 0; i < 9; i++)
            send_pixel(rand_pixel(i < 4 ? 1 : 0), 1'b1);
        drop_valid();
        wait_drained();
        write_reg(rwmf_pkg::REG_FRAME_WIDTH, 16'h0000);
        write_reg(rwmf_pkg::REG_FRAME_HEIGHT, 16'hFFFF);
        send_frame(3, 3, 1'b1);
        wait_drained();
        write_reg(rwmf_pkg::REG_FRAME_WIDTH, 16'hFFFF);
        write_reg(rwmf_pkg::REG_FRAME_HEIGHT, 16'd1);
        for (int i = 0; i < 40; i++)
            send_pixel(rand_pixel(2), 1'b0);
        drop_valid();
        wait_drained();
        write_reg(rwmf_pkg::REG_FRAME_WIDTH, 16'd1024);
        write_reg(rwmf_pkg::REG_FRAME_HEIGHT, 16'd4096);
        for (int i = 0; i < 40; i++)
            send_pixel(rand_pixel(2), 1'b1);
        drop_valid();
        wait_drained();

        // random frames, a few partial to exercise the restart on write
        while (pixels_sent < 560)
        begin
            w = $urandom_range(0, 9) == 0 ? $urandom_range(3, 40) : $urandom_range(3, 8);
            h = $urandom_range(3, 8);
            write_reg(rwmf_pkg::REG_FRAME_WIDTH, 16'(w));
            write_reg(rwmf_pkg::REG_FRAME_HEIGHT, 16'(h));
            out_stall_en = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, w * h - 1);
                for (int i = 0; i < n; i++)
                    send_pixel(rand_pixel(2), 1'b1);
                drop_valid();
            end
            else
            begin
                send_frame(w, h, $urandom_range(0, 3) != 0);
                if ($urandom_range(0, 1)) send_frame(w, h, 1'b1);
            end
            wait_drained();
        end

        out_stall_en = 1'b1;
        wait_drained();
        $display("sent %0d pixels, checked %0d medians over %0d complete frames",
            pixels_sent, medians_seen, frames_seen);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
